// ----- hw/rtl/fpw_pkg.sv -----
package fpw_pkg;

   // Input item operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_ENTRY = 1'b1;

   // Result kind codes
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Field widths
   localparam int AddrWidth  = 52;
   localparam int VaddrWidth = 48;
   localparam int EntryWidth = 64;
   localparam int PageShift  = 12;
   localparam int IndexWidth = 9;

   // Packed stream widths (padded to whole bytes)
   localparam int ReqDataWidth = 168;
   localparam int RspDataWidth = 112;

   typedef logic [1:0] level_type;

   // Controller to datapath commands
   typedef struct packed {
      logic      load_out;  // capture a result into the output register
      logic      start;     // save the virtual address of a new walk
      logic      use_root;  // table base comes from the root, not the entry
      level_type level;     // level of the entry being requested
      logic      done;      // result is a finished translation
      logic      fault;     // finished with a missing entry
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic present;        // present bit of the incoming entry
   } status_type;

   // 9-bit table index of a virtual address at a given level
   function automatic logic [IndexWidth-1:0] level_index(
      input logic [VaddrWidth-1:0] vaddr,
      input level_type             level
   );
      logic [IndexWidth-1:0] idx;
      begin
         case (level)
            2'd0:    idx = vaddr[47:39];
            2'd1:    idx = vaddr[38:30];
            2'd2:    idx = vaddr[29:21];
            default: idx = vaddr[20:12];
         endcase
         return idx;
      end
   endfunction

endpackage

// ----- hw/rtl/fpw_ctrl.sv -----
module fpw_ctrl
   import fpw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_op,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   // Walk state: idle or waiting on the entry of one level
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_L0   = 3'd1;
   localparam logic [2:0] ST_L1   = 3'd2;
   localparam logic [2:0] ST_L2   = 3'd3;
   localparam logic [2:0] ST_L3   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       accept;

   // Take a new transaction whenever the output register frees up this cycle
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      if (accept) begin
         if (req_op == OP_START) begin
            state_in     = ST_L0;
            cmd.load_out = 1'b1;
            cmd.start    = 1'b1;
            cmd.use_root = 1'b1;
            cmd.level    = 2'd0;
         end else if (state_ff != ST_IDLE) begin
            cmd.load_out = 1'b1;
            if (!status.present) begin
               state_in  = ST_IDLE;
               cmd.done  = 1'b1;
               cmd.fault = 1'b1;
            end else begin
               unique case (state_ff)
                  ST_L0: begin
                     state_in  = ST_L1;
                     cmd.level = 2'd1;
                  end
                  ST_L1: begin
                     state_in  = ST_L2;
                     cmd.level = 2'd2;
                  end
                  ST_L2: begin
                     state_in  = ST_L3;
                     cmd.level = 2'd3;
                  end
                  default: begin
                     state_in  = ST_IDLE;
                     cmd.done  = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   // Output valid: set on a new result, cleared once taken
   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // A result is only produced by an accepted transaction
   a_load_needs_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> accept)
      else $error("result loaded without an accepted transaction");

   // A finished translation leaves the walker idle
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && cmd.done) |=> state_ff == ST_IDLE)
      else $error("walker not idle after finishing");

   // Entry data while idle produces nothing
   a_idle_entry_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_ENTRY && state_ff == ST_IDLE) |-> !cmd.load_out)
      else $error("entry data produced a result while idle");

   // A fault is always a finished result
   a_fault_is_done: assert property (@(posedge clock) disable iff (reset)
      cmd.fault |-> cmd.done)
      else $error("fault flagged on a read request");

endmodule

// ----- hw/rtl/fpw_datapath.sv -----
module fpw_datapath
   import fpw_pkg::*;
(
   input  logic                  clock,
   input  cmd_type               cmd,
   input  logic [AddrWidth-1:0]  root_table,
   input  logic [VaddrWidth-1:0] virt_addr,
   input  logic [EntryWidth-1:0] entry_data,
   output status_type            status,
   output logic                  result_kind,
   output logic [AddrWidth-1:0]  read_addr,
   output logic [AddrWidth-1:0]  phys_addr,
   output logic                  fault
);

   logic [VaddrWidth-1:0] vaddr_ff, vaddr_in;
   logic [VaddrWidth-1:0] idx_vaddr;
   logic [AddrWidth-1:0]  base;
   logic [IndexWidth-1:0] idx;

   logic                 kind_ff, kind_in;
   logic [AddrWidth-1:0] raddr_ff, raddr_in;
   logic [AddrWidth-1:0] paddr_ff, paddr_in;
   logic                 fault_ff, fault_in;

   assign status.present = entry_data[0];

   // Saved virtual address of the current walk
   assign vaddr_in = cmd.start ? virt_addr : vaddr_ff;

   // Entry address: frame base with index times eight in the low 12 bits
   assign idx_vaddr = cmd.start ? virt_addr : vaddr_ff;
   assign idx       = level_index(idx_vaddr, cmd.level);
   assign base      = cmd.use_root ? root_table : entry_data[AddrWidth-1:0];

   // Result fields
   always_comb begin
      kind_in  = cmd.done ? KIND_DONE : KIND_READ;
      fault_in = cmd.fault;
      raddr_in = '0;
      paddr_in = '0;
      if (!cmd.done) begin
         raddr_in = {base[AddrWidth-1:PageShift], idx, 3'b000};
      end else if (!cmd.fault) begin
         paddr_in = {entry_data[AddrWidth-1:PageShift], vaddr_ff[PageShift-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      vaddr_ff <= vaddr_in;
      if (cmd.load_out) begin
         kind_ff  <= kind_in;
         raddr_ff <= raddr_in;
         paddr_ff <= paddr_in;
         fault_ff <= fault_in;
      end
   end

   assign result_kind = kind_ff;
   assign read_addr   = raddr_ff;
   assign phys_addr   = paddr_ff;
   assign fault       = fault_ff;

endmodule

// ----- hw/rtl/four_level_page_walker_top.sv -----
// Four-level page table walker, 4 KiB pages, 48-bit virtual addresses.
// Input stream (req_): tuser is the operation, 0 = start a walk with the root
// table address and virtual address, 1 = table entry read data returned.
// Result stream (rsp_): tuser is the kind, 0 = entry read request carrying
// read_addr, 1 = translation finished carrying phys_addr and the fault flag.
// Every start yields a read request for the top level; every entry returned
// to an active walk yields the next read request, or the finished result
// after the fourth level or on a missing present bit. Entry data while idle
// is dropped without a result. A start during a walk abandons it.
// A result appears in the cycle after its input transaction, from the
// output register. Throughput: one transaction per cycle, set by the single
// result register; req_tready stays high while that register is empty or
// being drained, and drops only while rsp_tvalid is held by rsp_tready low.
// Reset (synchronous, active high) returns the walker to idle and empties
// the output register.
module four_level_page_walker_top
   import fpw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tuser,  // operation
   // root_table[51:0], virt_addr[99:52], entry_data[163:100], zero pad
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic                    rsp_tuser,  // result_kind
   // read_addr[51:0], phys_addr[103:52], fault[104], zero pad
   output logic [RspDataWidth-1:0] rsp_tdata
);

   cmd_type              cmd;
   status_type           status;
   logic [AddrWidth-1:0] read_addr;
   logic [AddrWidth-1:0] phys_addr;
   logic                 fault;

   fpw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fpw_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .root_table  (req_tdata[51:0]),
      .virt_addr   (req_tdata[99:52]),
      .entry_data  (req_tdata[163:100]),
      .status      (status),
      .result_kind (rsp_tuser),
      .read_addr   (read_addr),
      .phys_addr   (phys_addr),
      .fault       (fault)
   );

   // Pack the result fields
   assign rsp_tdata = {7'b0, fault, phys_addr, read_addr};

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

import fpw_pkg::*;

// One result transaction as it leaves the walker
typedef struct packed {
   logic                 kind;
   logic [AddrWidth-1:0] read_addr;
   logic [AddrWidth-1:0] phys_addr;
   logic                 fault;
} walk_result_type;

// Tracks the walk state and holds the results each request transaction should produce
class walk_scoreboard;
   walk_result_type       expected_q[$];
   logic [1:0]            cur_level;
   bit                    walking;
   logic [VaddrWidth-1:0] walk_vaddr;
   int                    errors;
   int                    reads_checked;
   int                    walks_finished;
   int                    walks_faulted;

   function new();
      cur_level      = 2'd0;
      walking        = 1'b0;
      walk_vaddr     = '0;
      errors         = 0;
      reads_checked  = 0;
      walks_finished = 0;
      walks_faulted  = 0;
   endfunction

   // Table base frame plus 9-bit index of the saved address times eight
   function logic [AddrWidth-1:0] entry_addr(logic [AddrWidth-1:0] base, logic [1:0] lvl);
      int          shift;
      logic [8:0]  idx;
      shift = 39 - 9 * int'(lvl);
      idx   = 9'(walk_vaddr >> shift);
      return {base[AddrWidth-1:PageShift], 12'h000} + {40'd0, idx, 3'b000};
   endfunction

   // Returns 1 when the accepted transaction produces a result
   function bit note_request(logic op, logic [AddrWidth-1:0] root,
                             logic [VaddrWidth-1:0] va, logic [EntryWidth-1:0] entry);
      walk_result_type r;
      r = '0;
      if (op == OP_START) begin
         walk_vaddr  = va;
         cur_level   = 2'd0;
         walking     = 1'b1;
         r.kind      = KIND_READ;
         r.read_addr = entry_addr(root, 2'd0);
      end else if (!walking) begin
         return 1'b0;
      end else if (!entry[0]) begin
         // missing entry ends the walk
         walking   = 1'b0;
         cur_level = 2'd0;
         r.kind    = KIND_DONE;
         r.fault   = 1'b1;
      end else if (cur_level != 2'd3) begin
         cur_level   = cur_level + 2'd1;
         r.kind      = KIND_READ;
         r.read_addr = entry_addr(entry[AddrWidth-1:0], cur_level);
      end else begin
         walking     = 1'b0;
         cur_level   = 2'd0;
         r.kind      = KIND_DONE;
         r.phys_addr = {entry[AddrWidth-1:PageShift], walk_vaddr[PageShift-1:0]};
      end
      expected_q.push_back(r);
      return 1'b1;
   endfunction

   function void check_response(walk_result_type got);
      walk_result_type exp;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result kind=%0b read=%h phys=%h fault=%0b",
                  $time, got.kind, got.read_addr, got.phys_addr, got.fault);
         errors++;
         return;
      end
      exp = expected_q.pop_front();
      if (got.kind !== exp.kind) begin
         $display("%0t: kind mismatch, expected %0b actual %0b", $time, exp.kind, got.kind);
         errors++;
      end
      if (got.read_addr !== exp.read_addr) begin
         $display("%0t: read_addr mismatch, expected %h actual %h",
                  $time, exp.read_addr, got.read_addr);
         errors++;
      end
      if (got.phys_addr !== exp.phys_addr) begin
         $display("%0t: phys_addr mismatch, expected %h actual %h",
                  $time, exp.phys_addr, got.phys_addr);
         errors++;
      end
      if (got.fault !== exp.fault) begin
         $display("%0t: fault mismatch, expected %0b actual %0b", $time, exp.fault, got.fault);
         errors++;
      end
      if (exp.kind == KIND_READ) reads_checked++;
      else if (exp.fault) walks_faulted++;
      else walks_finished++;
   endfunction
endclass

module tb_top;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic                    req_tuser;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic                    rsp_tuser;
   logic [RspDataWidth-1:0] rsp_tdata;

   walk_scoreboard sb = new();

   int items_sent;
   int items_dropped;
   int restarts;
   bit req_steady;
   bit rsp_steady;

   four_level_page_walker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   function logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Drive one request transaction and wait for it to be taken
   task send_item(input logic op, input logic [AddrWidth-1:0] root,
                  input logic [VaddrWidth-1:0] va, input logic [EntryWidth-1:0] entry);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, entry, va, root};
      do @(posedge clock); while (!req_tready);
      if (sb.note_request(op, root, va, entry)) items_sent++;
      else items_dropped++;
   endtask

   // Extremes and corner cases of the walk
   task run_directed();
      send_item(OP_ENTRY, '1, '1, '1);          // entry with no walk: dropped
      send_item(OP_START, '1, '1, '0);          // all-ones root and address
      repeat (4) send_item(OP_ENTRY, '0, '0, '1);
      send_item(OP_START, '0, '0, '1);          // walk to physical address zero
      repeat (4) send_item(OP_ENTRY, '1, '1, 64'h1);
      send_item(OP_START, 52'h0_0000_0000_1FFF, 48'h8040_2010_0ABC, '0);
      send_item(OP_ENTRY, '0, '0, 64'h0);       // not present at top level
      send_item(OP_ENTRY, '0, '0, 64'h1);       // after fault: dropped
      send_item(OP_START, 52'hA_BCDE_F012_3000, 48'h1234_5678_9ABC, '0);
      send_item(OP_ENTRY, '0, '0, 64'h0000_0001_2345_6001);
      send_item(OP_START, 52'h5_5555_5555_5555, 48'h7FFF_FFFF_FFFF, '0);  // restart
      repeat (3) send_item(OP_ENTRY, '0, '0, 64'h000F_FFFF_FFFF_F001);
      send_item(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);               // last level fault
      send_item(OP_START, 52'h0_0000_0000_0000, 48'hFFFF_FFFF_FFFF, '0);
      repeat (4) send_item(OP_ENTRY, '0, '0, 64'hFFF0_0000_0000_0FFF);    // junk bits only
   endtask

   // One walk with random content, sometimes broken or with noise around it
   task random_walk();
      logic [EntryWidth-1:0] entry;
      int                    lvl;
      if ($urandom_range(0, 19) == 0) req_steady = ~req_steady;
      if ($urandom_range(0, 19) == 0) rsp_steady = ~rsp_steady;
      if ($urandom_range(0, 9) == 0)
         send_item(logic'($urandom_range(0, 1)), AddrWidth'(rand64()),
                   VaddrWidth'(rand64()), rand64());
      send_item(OP_START, AddrWidth'(rand64()), VaddrWidth'(rand64()), rand64());
      for (lvl = 0; lvl < 4; lvl++) begin
         if ($urandom_range(0, 39) == 0) begin
            send_item(OP_START, AddrWidth'(rand64()), VaddrWidth'(rand64()), rand64());
            restarts++;
         end
         entry    = rand64();
         entry[0] = ($urandom_range(0, 19) != 0);
         send_item(OP_ENTRY, AddrWidth'(rand64()), VaddrWidth'(rand64()), entry);
         if (!entry[0]) break;
      end
      if ($urandom_range(0, 9) == 0)
         send_item(OP_ENTRY, AddrWidth'(rand64()), VaddrWidth'(rand64()), rand64());
   endtask

   // Result side: random stall before each transaction
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response({rsp_tuser, rsp_tdata[51:0], rsp_tdata[103:52], rsp_tdata[104]});
   end

   // Main sequence
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_START;
      req_tdata  <= '0;
      items_sent    = 0;
      items_dropped = 0;
      restarts      = 0;
      req_steady    = 1'b0;
      rsp_steady    = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      while (items_sent < 1750) random_walk();
      req_tvalid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d request transactions (%0d dropped as stray entries, %0d restarts)",
               items_sent + items_dropped, items_dropped, restarts);
      $display("Checked %0d read requests, %0d good translations, %0d faulted walks",
               sb.reads_checked, sb.walks_finished, sb.walks_faulted);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
